// ===== rtl/dcyf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcyf_pkg
// Shared types, constants and date helpers for the day count / year fraction
// unit: request and response structs, divisor constants and reciprocals.
// ----------------------------------------------------------------------------
package dcyf_pkg;

	// fixed point fraction bits of the year fraction
	localparam int unsigned FRAC_BITS = 32;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 22;
	localparam int unsigned YFRAC_W = 46;

	// width of the per-divisor fraction step constant, 2^FRAC_BITS / 360 < 2^(FRAC_BITS-8)
	localparam int unsigned K_W = FRAC_BITS - 8;

	localparam logic [COUNT_W-1:0] DAYS_MAX = '1;
	localparam logic [YFRAC_W-1:0] FRAC_MAX = '1;

	// divisors and rounding offsets (half the divisor)
	localparam logic [8:0] DIV_ACT  = 9'd365;
	localparam logic [8:0] DIV_30   = 9'd360;
	localparam logic [8:0] HALF_ACT = 9'd182;
	localparam logic [8:0] HALF_30  = 9'd180;

	// count / divisor by reciprocal, exact for a 22-bit count
	localparam int unsigned Q_SHIFT = 31;
	localparam int unsigned QMUL_W  = 23;
	localparam logic [QMUL_W-1:0] Q_MUL_ACT =
		QMUL_W'(((64'd1 << Q_SHIFT) + 64'd364) / 64'd365);
	localparam logic [QMUL_W-1:0] Q_MUL_30 =
		QMUL_W'(((64'd1 << Q_SHIFT) + 64'd359) / 64'd360);

	// small remainder term / divisor by reciprocal, exact below 2^18
	localparam int unsigned T_SHIFT = 27;
	localparam int unsigned TMUL_W  = 19;
	localparam logic [TMUL_W-1:0] T_MUL_ACT =
		TMUL_W'(((64'd1 << T_SHIFT) + 64'd364) / 64'd365);
	localparam logic [TMUL_W-1:0] T_MUL_30 =
		TMUL_W'(((64'd1 << T_SHIFT) + 64'd359) / 64'd360);

	// 2^FRAC_BITS = div * K + R0
	localparam logic [63:0] K_ACT  = (64'd1 << FRAC_BITS) / 64'd365;
	localparam logic [63:0] K_30   = (64'd1 << FRAC_BITS) / 64'd360;
	localparam logic [63:0] R0_ACT = (64'd1 << FRAC_BITS) % 64'd365;
	localparam logic [63:0] R0_30  = (64'd1 << FRAC_BITS) % 64'd360;

	// year / 100 by reciprocal, exact for any 14-bit year
	localparam int unsigned Y100_SHIFT = 21;
	localparam logic [14:0] Y100_MUL   = 15'd20972;

	typedef enum logic {
		CONV_ACT365 = 1'b0,
		CONV_30360  = 1'b1
	} conv_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
		logic [YEAR_W-1:0]  end_year;
		logic [MONTH_W-1:0] end_month;
		logic [DAY_W-1:0]   end_day;
		conv_t              convention;
	} dcyf_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic [YFRAC_W-1:0] year_fraction;
	} dcyf_rsp_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// days before the month, no leap day; months above twelve act as a full year
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd0:    n = 9'd0;
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd365;
		endcase
		return n;
	endfunction

	// serial day number: 365*y + leap years below y + day of year
	function automatic logic [22:0] day_number(
		input logic [YEAR_W-1:0]  y,
		input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0]   d,
		input logic [7:0]         q100
	);
		logic        div100;
		logic        div400;
		logic        leap;
		logic [13:0] m100;
		logic [12:0] c4;
		logic [7:0]  c100;
		logic [5:0]  c400;
		logic [12:0] lb;
		logic [8:0]  doy;
		m100   = 14'({6'b0, q100} * 14'd100);
		div100 = (m100 == y);
		div400 = div100 && (q100[1:0] == 2'b00);
		leap   = (y[1:0] == 2'b00) && (!div100 || div400);
		c4     = 13'((15'(y) + 15'd3) >> 2);
		c100   = q100 + 8'(!div100);
		c400   = q100[7:2] + 6'(!div400);
		lb     = c4 - 13'(c100) + 13'(c400);
		doy    = cum_days(m) + 9'(d) + 9'((m > 4'd2) && leap);
		return 23'(y) * 23'd365 + 23'(lb) + 23'(doy);
	endfunction

endpackage

// ===== rtl/day_count_year_fraction_unit.sv =====
// a request passes through nine pipeline registers on its way to rsp_valid
// throughput: one request per cycle while rsp_stall is low; every stage holds one request and moves when the
// stage after it is empty or moving, so rsp_stall ripples back to req_stall in the same cycle
// reset: arst_n clears the stage valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
// day_count_year_fraction_unit
// Day count and rounded fixed point year fraction between two dates under
// Actual/365 Fixed or 30/360, with closed-form leap year counting.
// ----------------------------------------------------------------------------
module day_count_year_fraction_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  dcyf_pkg::dcyf_req_t  req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output dcyf_pkg::dcyf_rsp_t  rsp_data
);
	import dcyf_pkg::*;

	localparam int unsigned NSTG = 9;
	localparam int unsigned QW   = 14;
	localparam int unsigned VW   = QW + FRAC_BITS;

	// pipeline control
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] vld_d;
	logic [NSTG-1:0] vld_in;
	logic [NSTG-1:0] adv;

	// stage payloads
	dcyf_req_t            req_s1;
	date_t                lo_s2, hi_s2, lo_s3, hi_s3;
	conv_t                conv_s2, conv_s3, conv_s4, conv_s5, conv_s6, conv_s7, conv_s8;
	logic [7:0]           q100lo_s3, q100hi_s3;
	logic signed [23:0]   d360_s3, d360_s4;
	logic [22:0]          dnlo_s4, dnhi_s4;
	logic [COUNT_W-1:0]   count_s5, count_s6, count_s7, count_s8;
	logic [QW-1:0]        q_s6, q_s7, q_s8;
	logic [8:0]           r_s7;
	logic [FRAC_BITS-1:0] rk_s8;
	logic [17:0]          t_s8;
	dcyf_rsp_t            rsp_q;

	// combinational per stage
	logic               swap;
	date_t              lo_d, hi_d;
	logic [28:0]        p100lo, p100hi;
	logic [DAY_W-1:0]   d0a, d1a;
	logic signed [23:0] dy24, dm24, dd24, d360_d;
	logic signed [23:0] days_act, days_sel;
	logic [COUNT_W-1:0] count_d;
	logic [QMUL_W-1:0]  qmul;
	logic [44:0]        qprod;
	logic [8:0]         div_sel;
	logic [21:0]        qd;
	logic [K_W-1:0]     k_sel;
	logic [8:0]         r0_sel, half_sel;
	logic [K_W+8:0]     rk_full;
	logic [17:0]        t_d;
	logic [TMUL_W-1:0]  tmul;
	logic [36:0]        tprod;
	logic [8:0]         u;
	logic [FRAC_BITS-1:0] frac;
	logic [VW-1:0]      v;
	logic [63:0]        v64;
	dcyf_rsp_t          rsp_d;

	// ready chain: a stage moves when it is empty or the next one moves
	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || !rsp_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		vld_in = {vld_q[NSTG-2:0], req_valid};
		vld_d  = (adv & vld_in) | (~adv & vld_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	assign req_stall = !adv[0];
	assign rsp_valid = vld_q[NSTG-1];
	assign rsp_data  = rsp_q;

	// stage 1: request register
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			req_s1 <= req_data;
		end
	end

	// stage 2: order the two dates
	always_comb begin
		swap = (req_s1.start_year > req_s1.end_year) ||
		       ((req_s1.start_year == req_s1.end_year) &&
		        (req_s1.start_month > req_s1.end_month)) ||
		       ((req_s1.start_year == req_s1.end_year) &&
		        (req_s1.start_month == req_s1.end_month) &&
		        (req_s1.start_day > req_s1.end_day));
		if (swap) begin
			lo_d = '{req_s1.end_year, req_s1.end_month, req_s1.end_day};
			hi_d = '{req_s1.start_year, req_s1.start_month, req_s1.start_day};
		end else begin
			lo_d = '{req_s1.start_year, req_s1.start_month, req_s1.start_day};
			hi_d = '{req_s1.end_year, req_s1.end_month, req_s1.end_day};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			lo_s2   <= lo_d;
			hi_s2   <= hi_d;
			conv_s2 <= req_s1.convention;
		end
	end

	// stage 3: year / 100 and the 30/360 count
	always_comb begin
		p100lo = 29'(lo_s2.year) * 29'(Y100_MUL);
		p100hi = 29'(hi_s2.year) * 29'(Y100_MUL);
		d0a    = (lo_s2.day == 5'd31) ? 5'd30 : lo_s2.day;
		d1a    = ((hi_s2.day == 5'd31) && (d0a == 5'd30)) ? 5'd30 : hi_s2.day;
		dy24   = signed'(24'(hi_s2.year)) - signed'(24'(lo_s2.year));
		dm24   = signed'(24'(hi_s2.month)) - signed'(24'(lo_s2.month));
		dd24   = signed'(24'(d1a)) - signed'(24'(d0a));
		d360_d = dy24 * 24'sd360 + dm24 * 24'sd30 + dd24;
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			lo_s3     <= lo_s2;
			hi_s3     <= hi_s2;
			q100lo_s3 <= p100lo[Y100_SHIFT +: 8];
			q100hi_s3 <= p100hi[Y100_SHIFT +: 8];
			d360_s3   <= d360_d;
			conv_s3   <= conv_s2;
		end
	end

	// stage 4: serial day numbers of both dates
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			dnlo_s4 <= day_number(lo_s3.year, lo_s3.month, lo_s3.day, q100lo_s3);
			dnhi_s4 <= day_number(hi_s3.year, hi_s3.month, hi_s3.day, q100hi_s3);
			d360_s4 <= d360_s3;
			conv_s4 <= conv_s3;
		end
	end

	// stage 5: pick convention and clamp the count
	always_comb begin
		days_act = signed'(24'(dnhi_s4)) - signed'(24'(dnlo_s4));
		days_sel = (conv_s4 == CONV_30360) ? d360_s4 : days_act;
		if (days_sel < 24'sd0) begin
			count_d = '0;
		end else if (days_sel > signed'(24'(DAYS_MAX))) begin
			count_d = DAYS_MAX;
		end else begin
			count_d = days_sel[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			count_s5 <= count_d;
			conv_s5  <= conv_s4;
		end
	end

	// stage 6: whole years, count / divisor by reciprocal
	always_comb begin
		qmul  = (conv_s5 == CONV_30360) ? Q_MUL_30 : Q_MUL_ACT;
		qprod = 45'(count_s5) * 45'(qmul);
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			q_s6     <= qprod[Q_SHIFT +: QW];
			count_s6 <= count_s5;
			conv_s6  <= conv_s5;
		end
	end

	// stage 7: remainder of the division
	always_comb begin
		div_sel = (conv_s6 == CONV_30360) ? DIV_30 : DIV_ACT;
		qd      = 22'(q_s6) * 22'(div_sel);
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			r_s7     <= 9'(count_s6 - qd);
			q_s7     <= q_s6;
			count_s7 <= count_s6;
			conv_s7  <= conv_s6;
		end
	end

	// stage 8: r * 2^F = div * (r * K) + r * R0, split into two products
	always_comb begin
		k_sel    = (conv_s7 == CONV_30360) ? K_30[K_W-1:0] : K_ACT[K_W-1:0];
		r0_sel   = (conv_s7 == CONV_30360) ? R0_30[8:0] : R0_ACT[8:0];
		half_sel = (conv_s7 == CONV_30360) ? HALF_30 : HALF_ACT;
		rk_full  = {9'b0, k_sel} * {{K_W{1'b0}}, r_s7};
		t_d      = 18'(r_s7) * 18'(r0_sel) + 18'(half_sel);
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			rk_s8    <= rk_full[FRAC_BITS-1:0];
			t_s8     <= t_d;
			q_s8     <= q_s7;
			count_s8 <= count_s7;
			conv_s8  <= conv_s7;
		end
	end

	// stage 9: rounded fraction, join with whole years and saturate
	always_comb begin
		tmul  = (conv_s8 == CONV_30360) ? T_MUL_30 : T_MUL_ACT;
		tprod = 37'(t_s8) * 37'(tmul);
		u     = tprod[T_SHIFT +: 9];
		frac  = rk_s8 + {{(FRAC_BITS-9){1'b0}}, u};
		v     = {q_s8, frac};
		v64   = 64'(v);
		rsp_d.day_count = count_s8;
		if (v64 > 64'(FRAC_MAX)) begin
			rsp_d.year_fraction = FRAC_MAX;
		end else begin
			rsp_d.year_fraction = v64[YFRAC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			rsp_q <= rsp_d;
		end
	end

	// a full pipeline under a stalled response takes no request
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && rsp_stall |-> req_stall)
		else $error("request taken while pipeline full and response stalled");

	// an accepted request lands in the first stage
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_q[0])
		else $error("accepted request lost at first stage");

	// zero days gives a zero fraction
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.day_count == '0) |-> (rsp_data.year_fraction == '0))
		else $error("nonzero year fraction for zero days");

	// under 360 days the fraction stays below one
	a_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.day_count < 22'd360) |->
		(64'(rsp_data.year_fraction) < (64'd1 << FRAC_BITS)))
		else $error("year fraction of one or more for under 360 days");

endmodule

// ===== tb/sv/day_count_year_fraction_unit_test.sv =====
// ----------------------------------------------------------------------------
// day_count_year_fraction_unit_test
// Self-checking bench for the day count / year fraction unit. A short table of
// directed date pairs (leap rules, odd months and days, swaps, saturation) is
// followed by random date pairs. Every response is compared field by field
// with a typed table value or an in-bench calculation of the day count and
// rounded fraction, while both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module day_count_year_fraction_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dcyf_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1876;
	localparam int unsigned TAIL_ITEMS   = 150;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned REPORT_MAX   = 10;

	// days before each month, leap day not included; months past twelve are a full year
	localparam int unsigned MONTH_START [16] = '{
		0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
	};

	typedef struct {
		int unsigned     y0, m0, d0, y1, m1, d1;
		conv_t           conv;
		bit              typed;
		int unsigned     count;
		longint unsigned frac;
	} date_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	dcyf_req_t req_data = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	dcyf_rsp_t rsp_data;

	date_row_t   directed_rows [$];
	dcyf_rsp_t   owed_fractions [$];
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned saturated_counts = 0;
	int unsigned act_requests = 0;
	int unsigned thirty_requests = 0;
	int unsigned stall_left = 0;
	int unsigned stall_pct = 30;
	bit          tail_phase = 1'b0;

	day_count_year_fraction_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// gregorian leap rule, year zero included
	function automatic bit leap_year(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// leap years in [0, y)
	function automatic longint leaps_before(longint y);
		return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic longint ordinal_in_year(longint y, longint m, longint d);
		longint n;
		n = longint'(MONTH_START[m]) + d;
		if (m > 2 && leap_year(y))
			n = n + 1;
		return n;
	endfunction

	// count / div as fixed point, half the divisor added for rounding
	function automatic longint unsigned to_fixed(longint unsigned cnt, longint unsigned div);
		longint unsigned q;
		longint unsigned r;
		longint unsigned v;
		q = cnt / div;
		r = cnt % div;
		v = (q << FRAC_BITS) + (((r << FRAC_BITS) + div / 2) / div);
		if (v > longint'(FRAC_MAX))
			v = longint'(FRAC_MAX);
		return v;
	endfunction

	function automatic dcyf_rsp_t predict_year_fraction(dcyf_req_t r);
		longint          y0, m0, d0, y1, m1, d1, t, days;
		longint unsigned cnt;
		longint unsigned div;
		dcyf_rsp_t       res;
		y0 = r.start_year;
		m0 = r.start_month;
		d0 = r.start_day;
		y1 = r.end_year;
		m1 = r.end_month;
		d1 = r.end_day;
		// order the dates
		if (y0 > y1 || (y0 == y1 && m0 > m1) || (y0 == y1 && m0 == m1 && d0 > d1)) begin
			t = y0; y0 = y1; y1 = t;
			t = m0; m0 = m1; m1 = t;
			t = d0; d0 = d1; d1 = t;
		end
		if (r.convention == CONV_ACT365) begin
			days = 365 * (y1 - y0) + (leaps_before(y1) - leaps_before(y0))
				+ ordinal_in_year(y1, m1, d1) - ordinal_in_year(y0, m0, d0);
			div = 365;
		end else begin
			if (d0 == 31)
				d0 = 30;
			if (d1 == 31 && d0 == 30)
				d1 = 30;
			days = 360 * (y1 - y0) + 30 * (m1 - m0) + (d1 - d0);
			div = 360;
		end
		// clamp to the count range
		if (days < 0)
			cnt = 0;
		else if (days > longint'(DAYS_MAX))
			cnt = longint'(DAYS_MAX);
		else
			cnt = days;
		res.day_count     = COUNT_W'(cnt);
		res.year_fraction = YFRAC_W'(to_fixed(cnt, div));
		return res;
	endfunction

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		case (m)
			2:             return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// mostly well-formed dates, some near pairs, huge years and raw noise
	function automatic dcyf_req_t random_date_pair();
		dcyf_req_t   r;
		int unsigned kind;
		int unsigned ya, yb, ma, mb;
		kind = $urandom_range(0, 9);
		r.convention = conv_t'($urandom_range(0, 1));
		if (kind >= 8) begin
			r.start_year  = YEAR_W'($urandom);
			r.start_month = MONTH_W'($urandom);
			r.start_day   = DAY_W'($urandom);
			r.end_year    = YEAR_W'($urandom);
			r.end_month   = MONTH_W'($urandom);
			r.end_day     = DAY_W'($urandom);
		end else begin
			if (kind == 7) begin
				ya = $urandom_range(0, 16383);
				yb = $urandom_range(0, 16383);
			end else if (kind >= 5) begin
				ya = $urandom_range(1, 9999);
				yb = ya + $urandom_range(0, 1);
			end else begin
				ya = $urandom_range(1, 9999);
				yb = $urandom_range(1, 9999);
			end
			ma = $urandom_range(1, 12);
			mb = $urandom_range(1, 12);
			r.start_year  = YEAR_W'(ya);
			r.start_month = MONTH_W'(ma);
			r.end_year    = YEAR_W'(yb);
			r.end_month   = MONTH_W'(mb);
			// month ends stress the 30/360 day rules
			if (kind == 5 || kind == 6) begin
				r.start_day = DAY_W'($urandom_range(28, month_length(ya, ma)));
				r.end_day   = DAY_W'($urandom_range(28, month_length(yb, mb)));
			end else begin
				r.start_day = DAY_W'($urandom_range(1, month_length(ya, ma)));
				r.end_day   = DAY_W'($urandom_range(1, month_length(yb, mb)));
			end
		end
		return r;
	endfunction

	function automatic void add_row(int unsigned y0, int unsigned m0, int unsigned d0,
		int unsigned y1, int unsigned m1, int unsigned d1, conv_t conv,
		bit typed, int unsigned count, longint unsigned frac);
		date_row_t row;
		row.y0 = y0; row.m0 = m0; row.d0 = d0;
		row.y1 = y1; row.m1 = m1; row.d1 = d1;
		row.conv = conv;
		row.typed = typed;
		row.count = count;
		row.frac = frac;
		directed_rows.push_back(row);
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles,
				owed_fractions.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// response stall bursts, quiet in the tail
	always @(posedge clk) begin
		if (!arst_n || tail_phase) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 7);
		end else begin
			rsp_stall <= 1'b0;
		end
		if (cycles % 128 == 0)
			stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : 30;
	end

	// response check against the oldest owed result
	always @(posedge clk) begin
		dcyf_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_fractions.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected response: day_count %0d year_fraction 0x%0h",
						rsp_data.day_count, rsp_data.year_fraction);
			end else begin
				want = owed_fractions.pop_front();
				results_checked++;
				if (rsp_data.day_count !== want.day_count) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("day_count mismatch: expected %0d, got %0d",
							want.day_count, rsp_data.day_count);
				end
				if (rsp_data.year_fraction !== want.year_fraction) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("year_fraction mismatch: expected 0x%0h, got 0x%0h",
							want.year_fraction, rsp_data.year_fraction);
				end
			end
		end
	end

	// request driver
	initial begin
		int unsigned total;
		int unsigned gap;
		int unsigned send_gap_pct;
		dcyf_req_t   next;
		dcyf_rsp_t   owed;
		date_row_t   row;
		bit          use_row;

		// identical dates, one plain year, swapped order
		add_row(2000, 1, 1, 2000, 1, 1, CONV_ACT365, 1'b1, 0, 0);
		add_row(2000, 1, 1, 2000, 1, 1, CONV_30360, 1'b1, 0, 0);
		add_row(2001, 1, 1, 2002, 1, 1, CONV_ACT365, 1'b1, 365, 64'd1 << FRAC_BITS);
		add_row(2001, 1, 1, 2002, 1, 1, CONV_30360, 1'b1, 360, 64'd1 << FRAC_BITS);
		add_row(2002, 1, 1, 2001, 1, 1, CONV_ACT365, 1'b1, 365, 64'd1 << FRAC_BITS);
		// leap day rules: by 400, century, by 4, year zero
		add_row(2000, 2, 28, 2000, 3, 1, CONV_ACT365, 1'b0, 0, 0);
		add_row(1900, 2, 28, 1900, 3, 1, CONV_ACT365, 1'b0, 0, 0);
		add_row(2004, 2, 28, 2004, 3, 1, CONV_ACT365, 1'b0, 0, 0);
		add_row(0, 2, 28, 0, 3, 1, CONV_ACT365, 1'b0, 0, 0);
		// 30/360 day 31 handling
		add_row(2019, 1, 31, 2019, 3, 31, CONV_30360, 1'b0, 0, 0);
		add_row(2019, 1, 30, 2019, 3, 31, CONV_30360, 1'b0, 0, 0);
		add_row(2019, 1, 29, 2019, 3, 31, CONV_30360, 1'b0, 0, 0);
		// month zero acts like january, month thirteen like next new year
		add_row(2019, 0, 5, 2019, 1, 5, CONV_ACT365, 1'b1, 0, 0);
		add_row(2019, 13, 1, 2020, 1, 1, CONV_ACT365, 1'b1, 0, 0);
		add_row(2020, 15, 31, 2021, 0, 0, CONV_ACT365, 1'b0, 0, 0);
		// out of range days driving the count negative
		add_row(2000, 2, 31, 2000, 3, 0, CONV_ACT365, 1'b1, 0, 0);
		add_row(2000, 15, 1, 2001, 0, 1, CONV_30360, 1'b1, 0, 0);
		// field extremes and saturation
		add_row(0, 1, 1, 16383, 15, 31, CONV_ACT365, 1'b0, 0, 0);
		add_row(0, 0, 0, 16383, 15, 31, CONV_30360, 1'b0, 0, 0);
		add_row(16383, 15, 31, 0, 0, 0, CONV_ACT365, 1'b0, 0, 0);
		add_row(1, 1, 1, 9999, 12, 31, CONV_ACT365, 1'b0, 0, 0);
		add_row(1, 1, 1, 9999, 12, 31, CONV_30360, 1'b0, 0, 0);
		// short spans for rounding
		add_row(2023, 6, 15, 2023, 6, 16, CONV_ACT365, 1'b0, 0, 0);
		add_row(2001, 1, 1, 2001, 7, 2, CONV_30360, 1'b0, 0, 0);

		total = directed_rows.size() + RANDOM_ITEMS;
		send_gap_pct = 30;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned idx = 0; idx < total; idx++) begin
			use_row = (idx < directed_rows.size());
			if (use_row) begin
				row = directed_rows[idx];
				next.start_year  = YEAR_W'(row.y0);
				next.start_month = MONTH_W'(row.m0);
				next.start_day   = DAY_W'(row.d0);
				next.end_year    = YEAR_W'(row.y1);
				next.end_month   = MONTH_W'(row.m1);
				next.end_day     = DAY_W'(row.d1);
				next.convention  = row.conv;
			end else begin
				next = random_date_pair();
			end
			req_data <= next;
			req_valid <= 1'b1;
			@(posedge clk);
			while (req_stall)
				@(posedge clk);

			// request taken: record what it owes
			if (use_row && row.typed) begin
				owed.day_count     = COUNT_W'(row.count);
				owed.year_fraction = YFRAC_W'(row.frac);
			end else begin
				owed = predict_year_fraction(next);
			end
			owed_fractions.push_back(owed);
			if (owed.day_count == DAYS_MAX)
				saturated_counts++;
			if (next.convention == CONV_ACT365)
				act_requests++;
			else
				thirty_requests++;

			tail_phase = (idx + TAIL_ITEMS >= total);
			if (idx % 64 == 63)
				send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
			if (!tail_phase && $urandom_range(0, 99) < send_gap_pct) begin
				req_valid <= 1'b0;
				gap = $urandom_range(1, 8);
				repeat (gap)
					@(posedge clk);
			end
		end
		req_valid <= 1'b0;

		// drain, then allow for the pipeline depth
		while (owed_fractions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("%0d date pairs (%0d from the table), %0d Actual/365 and %0d 30/360",
			total, directed_rows.size(), act_requests, thirty_requests);
		$display("%0d responses checked, %0d saturated day counts, %0d mismatches",
			results_checked, saturated_counts, mismatches);
		if (mismatches == 0 && owed_fractions.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
